>>> hw/rtl/ntpt_pkg.sv
`timescale 1ns / 1ps

package ntpt_pkg;

   localparam int MAX_TRAILS = 32;
   localparam int SLOT_W     = $clog2(MAX_TRAILS);
   localparam int NOTES      = 128;
   localparam int MAP_AW     = $clog2(2 * NOTES);

   localparam logic [3:0] KIND_IN_ON     = 4'd0;
   localparam logic [3:0] KIND_IN_OFF    = 4'd1;
   localparam logic [3:0] KIND_OUT_ON    = 4'd2;
   localparam logic [3:0] KIND_OUT_OFF   = 4'd3;
   localparam logic [3:0] KIND_RELEASE   = 4'd4;
   localparam logic [3:0] KIND_CLEAR_IN  = 4'd5;
   localparam logic [3:0] KIND_TICK      = 4'd6;
   localparam logic [3:0] KIND_QUERY_IN  = 4'd7;
   localparam logic [3:0] KIND_QUERY_OUT = 4'd8;
   localparam logic [3:0] KIND_READ      = 4'd9;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [2:0] REG_VIS_LOW  = 3'd0;
   localparam logic [2:0] REG_VIS_HIGH = 3'd1;
   localparam logic [2:0] REG_ROLL_TOP = 3'd2;
   localparam logic [2:0] REG_ROLL_BOT = 3'd3;
   localparam logic [2:0] REG_MARGIN   = 3'd4;
   localparam logic [2:0] REG_MS_PX    = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MRD, ST_MWR, ST_SLOT, ST_TSCAN, ST_RWAIT, ST_RWR,
      ST_QWAIT, ST_QRES, ST_DSTART, ST_DIV, ST_DY, ST_SCROLL, ST_FIN
   } state_type;

   typedef struct packed {
      logic [6:0]  note;
      logic [4:0]  chan;
      logic [15:0] top;
      logic [15:0] bottom;
      logic [31:0] start_ms;
      logic [31:0] end_ms;
   } trail_rec_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [9:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [9:0]  rem;
   } div_rsp_type;

endpackage

>>> hw/rtl/ntpt_div.sv
`timescale 1ns / 1ps

module ntpt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ntpt_pkg::div_req_type dreq,
   output ntpt_pkg::div_rsp_type drsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] quo_ff;
   logic [9:0]  rem_ff;
   logic [10:0] trial;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign fits  = trial >= {1'b0, dreq.divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (dreq.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dreq.start) begin
         quo_ff <= dreq.dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= 10'(trial - {1'b0, dreq.divisor});
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial[9:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign drsp.done = done_ff;
   assign drsp.quot = quo_ff;
   assign drsp.rem  = rem_ff;

endmodule

>>> hw/rtl/note_trail_pool_tracker_core.sv
`timescale 1ns / 1ps
// Held-note maps and scrolling trail pool. One item at a time: req_ready is high only when
// the block is idle and no result is waiting. Queries read the note map, then report the
// lowest pressed channel; trail reads answer straight from the trail registers; note-on
// and note-off read and write the note map, then walk up to 32 trail slots (one slot a
// cycle); clear-input walks the trail slots; release-channel reads and writes each of
// the 128 input-map entries, then walks the trails; the first tick only records the time.
// A later tick runs the bit-serial divider, then a scroll walk when it moves the trails.

module note_trail_pool_tracker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_kind,
   input  logic [7:0]  req_channel,
   input  logic [7:0]  req_note,
   input  logic [31:0] req_now_ms,
   input  logic [4:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_spawned_slot,
   output logic [4:0]  rsp_pressed_channel,
   output logic        rsp_trail_live,
   output logic        rsp_trail_growing,
   output logic        rsp_trail_is_output,
   output logic [6:0]  rsp_trail_note,
   output logic [4:0]  rsp_trail_channel,
   output logic signed [15:0] rsp_trail_top,
   output logic signed [15:0] rsp_trail_bottom,
   output logic [31:0] rsp_trail_start_ms,
   output logic [31:0] rsp_trail_end_ms,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int NT = ntpt_pkg::MAX_TRAILS;
   localparam int SW = ntpt_pkg::SLOT_W;
   localparam int AW = ntpt_pkg::MAP_AW;
   localparam int NN = ntpt_pkg::NOTES;

   ntpt_pkg::state_type state_ff, state_in;

   logic [6:0]  vis_low_ff, vis_high_ff;
   logic [9:0]  roll_top_ff, roll_bot_ff, ms_px_ff;
   logic [7:0]  margin_ff;

   logic [3:0]  kind_ff;
   logic [4:0]  chan_ff;
   logic [6:0]  note_ff;
   logic        side_ff, mch_ff, mnote_ff;
   logic [SW-1:0] idx_ff;
   logic [9:0]  dy_ff;

   logic [31:0] last_ff, accum_ff;
   logic        started_ff;

   logic [15:0] map_mem [2*NN];
   logic [2*NN-1:0] map_vld_ff;
   logic [AW-1:0] addr_ff;
   logic [15:0] rdata_ff;
   logic        rvld_ff;
   logic [15:0] rd_eff;
   logic        mem_we;
   logic [15:0] mem_wdata;
   logic        clr_in;

   logic [NT-1:0] live_ff, grow_ff, isout_ff;
   ntpt_pkg::trail_rec_type rec_ff [NT];

   logic        rsp_valid_ff;
   logic        accept;
   logic        ev_ok, ch_ok;
   logic        is_read;
   logic [15:0] bit_mask;
   logic [4:0]  low_ch;
   logic        last_idx, tmatch;
   logic [10:0] cap_raw;
   logic [9:0]  cap;
   logic [9:0]  dy_c;
   logic        cap_hit;
   logic [15:0] top_new, bot_new;
   logic signed [16:0] retire;

   ntpt_pkg::div_req_type dreq;
   ntpt_pkg::div_rsp_type drsp;

   ntpt_div u_div (.clock(clock), .reset(reset), .dreq(dreq), .drsp(drsp));

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ntpt_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   assign ch_ok = (req_channel >= 8'd1) && (req_channel <= 8'd16);
   assign ev_ok = ch_ok && !req_note[7] && (req_note[6:0] >= vis_low_ff)
                  && (req_note[6:0] <= vis_high_ff);
   assign is_read  = req_kind == ntpt_pkg::KIND_READ;
   assign bit_mask = 16'd1 << 4'(chan_ff - 5'd1);
   assign rd_eff   = rvld_ff ? rdata_ff : 16'd0;
   assign last_idx = idx_ff == SW'(NT - 1);
   assign tmatch   = live_ff[idx_ff] && grow_ff[idx_ff] && (isout_ff[idx_ff] == side_ff)
                     && (!mch_ff || rec_ff[idx_ff].chan == chan_ff)
                     && (!mnote_ff || rec_ff[idx_ff].note == note_ff);

   always_comb begin
      low_ch = 5'd0;
      for (int i = 15; i >= 0; i--) begin
         if (rd_eff[i]) low_ch = 5'(i + 1);
      end
   end

   assign cap_raw = {1'b0, roll_bot_ff} - {1'b0, roll_top_ff};
   assign cap     = (cap_raw[10] || cap_raw == 11'd0) ? 10'd1 : cap_raw[9:0];
   assign cap_hit = (ms_px_ff == 10'd0) || (drsp.quot >= {22'd0, cap});
   assign dy_c    = cap_hit ? cap : drsp.quot[9:0];

   assign top_new = rec_ff[idx_ff].top - {6'd0, dy_ff};
   assign bot_new = rec_ff[idx_ff].bottom - {6'd0, dy_ff};
   assign retire  = $signed({7'd0, roll_top_ff}) - $signed({9'd0, margin_ff});

   assign dreq.start    = state_ff == ntpt_pkg::ST_DSTART;
   assign dreq.dividend = accum_ff;
   assign dreq.divisor  = ms_px_ff;

   // map write and clear
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = rd_eff & ~bit_mask;
      clr_in    = accept && req_kind == ntpt_pkg::KIND_CLEAR_IN;
      if (state_ff == ntpt_pkg::ST_MWR) begin
         mem_we = 1'b1;
         if (!kind_ff[0]) mem_wdata = rd_eff | bit_mask;
      end else if (state_ff == ntpt_pkg::ST_RWR) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[addr_ff] <= mem_wdata;
      rdata_ff <= map_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         rvld_ff    <= 1'b0;
      end else begin
         rvld_ff <= map_vld_ff[addr_ff];
         if (mem_we) map_vld_ff[addr_ff] <= 1'b1;
         if (clr_in) map_vld_ff[NN-1:0] <= '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntpt_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind) inside
                  ntpt_pkg::KIND_IN_ON, ntpt_pkg::KIND_IN_OFF,
                  ntpt_pkg::KIND_OUT_ON, ntpt_pkg::KIND_OUT_OFF:
                     state_in = ev_ok ? ntpt_pkg::ST_MRD : ntpt_pkg::ST_FIN;
                  ntpt_pkg::KIND_RELEASE:
                     state_in = ch_ok ? ntpt_pkg::ST_RWAIT : ntpt_pkg::ST_FIN;
                  ntpt_pkg::KIND_CLEAR_IN: state_in = ntpt_pkg::ST_TSCAN;
                  ntpt_pkg::KIND_TICK:
                     state_in = started_ff ? ntpt_pkg::ST_DSTART : ntpt_pkg::ST_FIN;
                  ntpt_pkg::KIND_QUERY_IN, ntpt_pkg::KIND_QUERY_OUT:
                     state_in = req_note[7] ? ntpt_pkg::ST_FIN : ntpt_pkg::ST_QWAIT;
                  default: state_in = ntpt_pkg::ST_FIN;
               endcase
            end
         end
         ntpt_pkg::ST_MRD:    state_in = ntpt_pkg::ST_MWR;
         ntpt_pkg::ST_MWR:
            state_in = kind_ff[0] ? ntpt_pkg::ST_TSCAN : ntpt_pkg::ST_SLOT;
         ntpt_pkg::ST_SLOT:
            if (!live_ff[idx_ff] || last_idx) state_in = ntpt_pkg::ST_FIN;
         ntpt_pkg::ST_TSCAN:
            if (last_idx) state_in = ntpt_pkg::ST_FIN;
         ntpt_pkg::ST_RWAIT:  state_in = ntpt_pkg::ST_RWR;
         ntpt_pkg::ST_RWR:
            state_in = (addr_ff[AW-2:0] == '1) ? ntpt_pkg::ST_TSCAN : ntpt_pkg::ST_RWAIT;
         ntpt_pkg::ST_QWAIT:  state_in = ntpt_pkg::ST_QRES;
         ntpt_pkg::ST_QRES:   state_in = ntpt_pkg::ST_FIN;
         ntpt_pkg::ST_DSTART: state_in = ntpt_pkg::ST_DIV;
         ntpt_pkg::ST_DIV:
            if (drsp.done) state_in = ntpt_pkg::ST_DY;
         ntpt_pkg::ST_DY:
            state_in = (dy_c != 10'd0) ? ntpt_pkg::ST_SCROLL : ntpt_pkg::ST_FIN;
         ntpt_pkg::ST_SCROLL:
            if (last_idx) state_in = ntpt_pkg::ST_FIN;
         ntpt_pkg::ST_FIN:    state_in = ntpt_pkg::ST_IDLE;
         default:             state_in = ntpt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ntpt_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         vis_low_ff  <= 7'd21;
         vis_high_ff <= 7'd108;
         roll_top_ff <= 10'd0;
         roll_bot_ff <= 10'd240;
         margin_ff   <= 8'd8;
         ms_px_ff    <= 10'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            ntpt_pkg::REG_VIS_LOW:  vis_low_ff  <= csr_wdata[6:0];
            ntpt_pkg::REG_VIS_HIGH: vis_high_ff <= csr_wdata[6:0];
            ntpt_pkg::REG_ROLL_TOP: roll_top_ff <= csr_wdata;
            ntpt_pkg::REG_ROLL_BOT: roll_bot_ff <= csr_wdata;
            ntpt_pkg::REG_MARGIN:   margin_ff   <= csr_wdata[7:0];
            ntpt_pkg::REG_MS_PX:    ms_px_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state: tick time, trail flags, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         accum_ff     <= '0;
         started_ff   <= 1'b0;
         live_ff      <= '0;
         grow_ff      <= '0;
         isout_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ntpt_pkg::ST_IDLE:
               if (accept && req_kind == ntpt_pkg::KIND_TICK) begin
                  last_ff    <= req_now_ms;
                  started_ff <= 1'b1;
                  if (started_ff) accum_ff <= accum_ff + (req_now_ms - last_ff);
               end
            ntpt_pkg::ST_SLOT:
               if (!live_ff[idx_ff]) begin
                  live_ff[idx_ff]  <= 1'b1;
                  grow_ff[idx_ff]  <= 1'b1;
                  isout_ff[idx_ff] <= side_ff;
               end
            ntpt_pkg::ST_TSCAN:
               if (tmatch) grow_ff[idx_ff] <= 1'b0;
            ntpt_pkg::ST_DY:
               accum_ff <= cap_hit ? 32'd0 : {22'd0, drsp.rem};
            ntpt_pkg::ST_SCROLL:
               if (live_ff[idx_ff] && !grow_ff[idx_ff]
                   && $signed({bot_new[15], bot_new}) < retire)
                  live_ff[idx_ff] <= 1'b0;
            ntpt_pkg::ST_FIN: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // item context, map address, trail payload, result fields
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ntpt_pkg::ST_IDLE:
            if (accept) begin
               kind_ff             <= req_kind;
               chan_ff             <= req_channel[4:0];
               note_ff             <= req_note[6:0];
               side_ff             <= req_kind == ntpt_pkg::KIND_OUT_ON
                                      || req_kind == ntpt_pkg::KIND_OUT_OFF;
               mch_ff              <= req_kind != ntpt_pkg::KIND_CLEAR_IN;
               mnote_ff            <= req_kind != ntpt_pkg::KIND_RELEASE
                                      && req_kind != ntpt_pkg::KIND_CLEAR_IN;
               idx_ff              <= '0;
               addr_ff             <= (req_kind == ntpt_pkg::KIND_RELEASE) ? '0 :
                                      {req_kind == ntpt_pkg::KIND_OUT_ON
                                       || req_kind == ntpt_pkg::KIND_OUT_OFF
                                       || req_kind == ntpt_pkg::KIND_QUERY_OUT,
                                       req_note[6:0]};
               rsp_spawned_slot    <= '0;
               rsp_pressed_channel <= '0;
               rsp_trail_live      <= is_read && live_ff[SW'(req_slot)];
               rsp_trail_growing   <= is_read && grow_ff[SW'(req_slot)];
               rsp_trail_is_output <= is_read && isout_ff[SW'(req_slot)];
               rsp_trail_note      <= is_read ? rec_ff[SW'(req_slot)].note : '0;
               rsp_trail_channel   <= is_read ? rec_ff[SW'(req_slot)].chan : '0;
               rsp_trail_top       <= is_read ? rec_ff[SW'(req_slot)].top : '0;
               rsp_trail_bottom    <= is_read ? rec_ff[SW'(req_slot)].bottom : '0;
               rsp_trail_start_ms  <= is_read ? rec_ff[SW'(req_slot)].start_ms : '0;
               rsp_trail_end_ms    <= is_read ? rec_ff[SW'(req_slot)].end_ms : '0;
               case (req_kind) inside
                  ntpt_pkg::KIND_IN_ON, ntpt_pkg::KIND_IN_OFF,
                  ntpt_pkg::KIND_OUT_ON, ntpt_pkg::KIND_OUT_OFF:
                     rsp_status <= ev_ok ? ntpt_pkg::STATUS_DONE : ntpt_pkg::STATUS_IGNORED;
                  ntpt_pkg::KIND_RELEASE:
                     rsp_status <= ch_ok ? ntpt_pkg::STATUS_DONE : ntpt_pkg::STATUS_IGNORED;
                  ntpt_pkg::KIND_CLEAR_IN, ntpt_pkg::KIND_TICK,
                  ntpt_pkg::KIND_QUERY_IN, ntpt_pkg::KIND_QUERY_OUT,
                  ntpt_pkg::KIND_READ:
                     rsp_status <= ntpt_pkg::STATUS_DONE;
                  default: rsp_status <= ntpt_pkg::STATUS_IGNORED;
               endcase
            end
         ntpt_pkg::ST_SLOT: begin
            idx_ff <= idx_ff + SW'(1);
            if (!live_ff[idx_ff]) begin
               rec_ff[idx_ff].note     <= note_ff;
               rec_ff[idx_ff].chan     <= chan_ff;
               rec_ff[idx_ff].top      <= 16'({6'd0, roll_bot_ff} - 16'd1);
               rec_ff[idx_ff].bottom   <= 16'({6'd0, roll_bot_ff} - 16'd1);
               rec_ff[idx_ff].start_ms <= last_ff;
               rec_ff[idx_ff].end_ms   <= '0;
               rsp_spawned_slot        <= 5'(idx_ff);
            end else if (last_idx) begin
               rsp_status <= ntpt_pkg::STATUS_FULL;
            end
         end
         ntpt_pkg::ST_TSCAN: begin
            idx_ff <= idx_ff + SW'(1);
            if (tmatch) rec_ff[idx_ff].end_ms <= last_ff;
         end
         ntpt_pkg::ST_RWR: begin
            addr_ff <= addr_ff + AW'(1);
            idx_ff  <= '0;
         end
         ntpt_pkg::ST_QRES: rsp_pressed_channel <= low_ch;
         ntpt_pkg::ST_DY: begin
            dy_ff  <= dy_c;
            idx_ff <= '0;
         end
         ntpt_pkg::ST_SCROLL: begin
            idx_ff <= idx_ff + SW'(1);
            if (live_ff[idx_ff]) begin
               if (grow_ff[idx_ff]) begin
                  if ($signed(top_new) < $signed({6'd0, roll_top_ff}))
                     rec_ff[idx_ff].top <= {6'd0, roll_top_ff};
                  else
                     rec_ff[idx_ff].top <= top_new;
               end else begin
                  rec_ff[idx_ff].top    <= top_new;
                  rec_ff[idx_ff].bottom <= bot_new;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

>>> hw/rtl/ntpt_checker.sv
`timescale 1ns / 1ps

module ntpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status
);

   a_ready_only_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while a result waits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");

endmodule

bind note_trail_pool_tracker_core ntpt_checker u_ntpt_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status)
);

>>> sim/note_trail_pool_tracker_core_tb.sv
`timescale 1ns / 1ps

module note_trail_pool_tracker_core_tb;

   localparam logic [3:0] KIND_SPARE_LO = 4'd10;
   localparam logic [3:0] KIND_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  spawned;
      logic [4:0]  pressed;
      logic        live;
      logic        growing;
      logic        is_out;
      logic [6:0]  note;
      logic [4:0]  chan;
      logic [15:0] top;
      logic [15:0] bottom;
      logic [31:0] start_ms;
      logic [31:0] end_ms;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_kind = '0;
   logic [7:0]  req_channel = '0;
   logic [7:0]  req_note = '0;
   logic [31:0] req_now_ms = '0;
   logic [4:0]  req_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_spawned_slot;
   logic [4:0]  rsp_pressed_channel;
   logic        rsp_trail_live;
   logic        rsp_trail_growing;
   logic        rsp_trail_is_output;
   logic [6:0]  rsp_trail_note;
   logic [4:0]  rsp_trail_channel;
   logic signed [15:0] rsp_trail_top;
   logic signed [15:0] rsp_trail_bottom;
   logic [31:0] rsp_trail_start_ms;
   logic [31:0] rsp_trail_end_ms;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   // tracker image
   logic [15:0] in_map [ntpt_pkg::NOTES];
   logic [15:0] out_map [ntpt_pkg::NOTES];
   logic        tr_live [ntpt_pkg::MAX_TRAILS];
   logic        tr_grow [ntpt_pkg::MAX_TRAILS];
   logic        tr_out [ntpt_pkg::MAX_TRAILS];
   logic        tr_used [ntpt_pkg::MAX_TRAILS];
   logic [7:0]  tr_note [ntpt_pkg::MAX_TRAILS];
   logic [7:0]  tr_chan [ntpt_pkg::MAX_TRAILS];
   logic [15:0] tr_top [ntpt_pkg::MAX_TRAILS];
   logic [15:0] tr_bot [ntpt_pkg::MAX_TRAILS];
   logic [31:0] tr_start [ntpt_pkg::MAX_TRAILS];
   logic [31:0] tr_end [ntpt_pkg::MAX_TRAILS];
   logic [31:0] last_tick;
   logic        ticked;
   logic [31:0] accum;
   logic [9:0]  vis_low, vis_high, roll_top, roll_bot, margin, ms_px;

   result_type  expected_results [$];
   int          fails = 0;
   int          tx_idle = 11;
   int          rx_idle = 68;
   logic [31:0] clock_ms = 0;

   note_trail_pool_tracker_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle);
   end

   task automatic chk(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s expected %0h actual %0h", name, e, a);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            fails++;
         end else begin
            e = expected_results.pop_front();
            chk("status", 32'(e.status), 32'(rsp_status));
            chk("spawned_slot", 32'(e.spawned), 32'(rsp_spawned_slot));
            chk("pressed_channel", 32'(e.pressed), 32'(rsp_pressed_channel));
            chk("trail_live", 32'(e.live), 32'(rsp_trail_live));
            chk("trail_growing", 32'(e.growing), 32'(rsp_trail_growing));
            chk("trail_is_output", 32'(e.is_out), 32'(rsp_trail_is_output));
            chk("trail_note", 32'(e.note), 32'(rsp_trail_note));
            chk("trail_channel", 32'(e.chan), 32'(rsp_trail_channel));
            chk("trail_top", 32'(e.top), 32'($unsigned(rsp_trail_top)));
            chk("trail_bottom", 32'(e.bottom), 32'($unsigned(rsp_trail_bottom)));
            chk("trail_start_ms", e.start_ms, rsp_trail_start_ms);
            chk("trail_end_ms", e.end_ms, rsp_trail_end_ms);
         end
      end
   end

   function automatic logic [4:0] low_chan(input logic [15:0] bits);
      logic [4:0] c;
      c = 0;
      for (int i = 15; i >= 0; i--) if (bits[i]) c = 5'(i + 1);
      return c;
   endfunction

   task automatic halt_trails(input logic [7:0] ch, input logic [7:0] nt, input logic side,
                              input logic any_note, input logic any_chan);
      for (int i = 0; i < ntpt_pkg::MAX_TRAILS; i++)
         if (tr_live[i] && tr_grow[i] && tr_out[i] == side && (any_chan || tr_chan[i] == ch)
             && (any_note || tr_note[i] == nt)) begin
            tr_grow[i] = 1'b0;
            tr_end[i] = last_tick;
         end
   endtask

   task automatic scroll(input logic [31:0] dy);
      int retire;
      retire = int'(roll_top) - int'(margin);
      for (int i = 0; i < ntpt_pkg::MAX_TRAILS; i++) begin
         if (!tr_live[i]) continue;
         tr_top[i] = tr_top[i] - dy[15:0];
         if (tr_grow[i]) begin
            if (int'($signed(tr_top[i])) < int'(roll_top)) tr_top[i] = {6'd0, roll_top};
         end else begin
            tr_bot[i] = tr_bot[i] - dy[15:0];
            if (int'($signed(tr_bot[i])) < retire) tr_live[i] = 1'b0;
         end
      end
   endtask

   task automatic predict_result(input logic [3:0] kind, input logic [7:0] ch,
                                 input logic [7:0] nt, input logic [31:0] now,
                                 input logic [4:0] sl, output result_type r);
      logic        side, ok, found;
      int          cap;
      logic [31:0] q, dy;
      r = '0;
      side = (kind == ntpt_pkg::KIND_OUT_ON || kind == ntpt_pkg::KIND_OUT_OFF);
      ok = ch >= 1 && ch <= 16 && nt < 128 && nt >= vis_low && nt <= vis_high;
      case (kind)
         ntpt_pkg::KIND_IN_ON, ntpt_pkg::KIND_OUT_ON: begin
            if (!ok) r.status = ntpt_pkg::STATUS_IGNORED;
            else begin
               if (side) out_map[nt][ch - 1] = 1'b1;
               else in_map[nt][ch - 1] = 1'b1;
               found = 1'b0;
               for (int i = 0; i < ntpt_pkg::MAX_TRAILS; i++)
                  if (!found && !tr_live[i]) begin
                     found = 1'b1;
                     tr_live[i] = 1'b1; tr_grow[i] = 1'b1; tr_out[i] = side;
                     tr_used[i] = 1'b1; tr_note[i] = nt; tr_chan[i] = ch;
                     tr_top[i] = 16'(roll_bot - 1); tr_bot[i] = 16'(roll_bot - 1);
                     tr_start[i] = last_tick; tr_end[i] = 0;
                     r.spawned = 5'(i);
                  end
               r.status = found ? ntpt_pkg::STATUS_DONE : ntpt_pkg::STATUS_FULL;
            end
         end
         ntpt_pkg::KIND_IN_OFF, ntpt_pkg::KIND_OUT_OFF: begin
            if (!ok) r.status = ntpt_pkg::STATUS_IGNORED;
            else begin
               if (side) out_map[nt][ch - 1] = 1'b0;
               else in_map[nt][ch - 1] = 1'b0;
               halt_trails(ch, nt, side, 1'b0, 1'b0);
            end
         end
         ntpt_pkg::KIND_RELEASE: begin
            if (ch < 1 || ch > 16) r.status = ntpt_pkg::STATUS_IGNORED;
            else begin
               for (int n = 0; n < ntpt_pkg::NOTES; n++) in_map[n][ch - 1] = 1'b0;
               halt_trails(ch, 8'd0, 1'b0, 1'b1, 1'b0);
            end
         end
         ntpt_pkg::KIND_CLEAR_IN: begin
            for (int n = 0; n < ntpt_pkg::NOTES; n++) in_map[n] = '0;
            halt_trails(8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
         end
         ntpt_pkg::KIND_TICK: begin
            if (!ticked) begin
               last_tick = now;
               ticked = 1'b1;
            end else begin
               accum = accum + (now - last_tick);
               last_tick = now;
               cap = int'(roll_bot) - int'(roll_top);
               if (cap < 1) cap = 1;
               if (ms_px == 0) begin
                  dy = cap;
                  accum = 0;
               end else begin
                  q = accum / ms_px;
                  if (q >= cap) begin
                     dy = cap;
                     accum = 0;
                  end else begin
                     dy = q;
                     accum = accum - q * ms_px;
                  end
               end
               if (dy > 0) scroll(dy);
            end
         end
         ntpt_pkg::KIND_QUERY_IN: if (nt < 128) r.pressed = low_chan(in_map[nt]);
         ntpt_pkg::KIND_QUERY_OUT: if (nt < 128) r.pressed = low_chan(out_map[nt]);
         ntpt_pkg::KIND_READ: begin
            r.live = tr_live[sl]; r.growing = tr_grow[sl]; r.is_out = tr_out[sl];
            r.note = tr_note[sl][6:0]; r.chan = tr_chan[sl][4:0];
            r.top = tr_top[sl]; r.bottom = tr_bot[sl];
            r.start_ms = tr_start[sl]; r.end_ms = tr_end[sl];
         end
         default: r.status = ntpt_pkg::STATUS_IGNORED;
      endcase
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [3:0] kind, input logic [7:0] ch,
                            input logic [7:0] nt, input logic [31:0] now,
                            input logic [4:0] sl);
      result_type r;
      if ($urandom_range(99) < tx_idle) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind; req_channel = ch; req_note = nt; req_now_ms = now; req_slot = sl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_result(kind, ch, nt, now, sl, r);
      expected_results.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         ntpt_pkg::REG_VIS_LOW:  vis_low = {3'd0, val[6:0]};
         ntpt_pkg::REG_VIS_HIGH: vis_high = {3'd0, val[6:0]};
         ntpt_pkg::REG_ROLL_TOP: roll_top = val;
         ntpt_pkg::REG_ROLL_BOT: roll_bot = val;
         ntpt_pkg::REG_MARGIN:   margin = {2'd0, val[7:0]};
         default:                ms_px = val;
      endcase
   endtask

   task automatic set_regs(input int lo, input int hi, input int top, input int bot,
                           input int mar, input int mpp);
      write_reg(ntpt_pkg::REG_VIS_LOW, 10'(lo));
      write_reg(ntpt_pkg::REG_VIS_HIGH, 10'(hi));
      write_reg(ntpt_pkg::REG_ROLL_TOP, 10'(top));
      write_reg(ntpt_pkg::REG_ROLL_BOT, 10'(bot));
      write_reg(ntpt_pkg::REG_MARGIN, 10'(mar));
      write_reg(ntpt_pkg::REG_MS_PX, 10'(mpp));
   endtask

   task automatic tick_by(input logic [31:0] d);
      clock_ms = clock_ms + d;
      send_item(ntpt_pkg::KIND_TICK, 8'($urandom), 8'($urandom), clock_ms, 5'($urandom));
   endtask

   task automatic read_used(input int s);
      if (tr_used[s])
         send_item(ntpt_pkg::KIND_READ, 8'($urandom), 8'($urandom), $urandom, 5'(s));
   endtask

   task automatic test_directed();
      send_item(ntpt_pkg::KIND_IN_ON, 1, 21, 0, 0);
      tick_by(1000);
      send_item(ntpt_pkg::KIND_IN_ON, 16, 108, 0, 0);
      send_item(ntpt_pkg::KIND_IN_ON, 0, 60, 0, 0);
      send_item(ntpt_pkg::KIND_IN_ON, 17, 60, 0, 0);
      send_item(ntpt_pkg::KIND_OUT_ON, 255, 60, 0, 0);
      send_item(ntpt_pkg::KIND_IN_ON, 5, 20, 0, 0);
      send_item(ntpt_pkg::KIND_IN_ON, 5, 109, 0, 0);
      send_item(ntpt_pkg::KIND_IN_ON, 5, 200, 0, 0);
      send_item(ntpt_pkg::KIND_OUT_ON, 3, 64, 0, 0);
      send_item(ntpt_pkg::KIND_QUERY_IN, 0, 108, 0, 0);
      send_item(ntpt_pkg::KIND_QUERY_OUT, 0, 64, 0, 0);
      send_item(ntpt_pkg::KIND_QUERY_IN, 0, 255, 0, 0);
      tick_by(300);
      send_item(ntpt_pkg::KIND_OUT_OFF, 3, 64, 0, 0);
      send_item(ntpt_pkg::KIND_IN_OFF, 1, 21, 0, 0);
      send_item(ntpt_pkg::KIND_RELEASE, 16, 0, 0, 0);
      send_item(ntpt_pkg::KIND_RELEASE, 0, 0, 0, 0);
      send_item(ntpt_pkg::KIND_RELEASE, 200, 0, 0, 0);
      send_item(ntpt_pkg::KIND_CLEAR_IN, 0, 0, 0, 0);
      tick_by(32'hFFFF_F000);
      send_item(KIND_SPARE_LO, 1, 60, 0, 0);
      send_item(KIND_SPARE_HI, 1, 60, 0, 0);
      for (int s = 0; s < 3; s++) read_used(s);
   endtask

   task automatic test_pool_full();
      for (int i = 0; i < ntpt_pkg::MAX_TRAILS + 2; i++)
         send_item(i[0] ? ntpt_pkg::KIND_OUT_ON : ntpt_pkg::KIND_IN_ON, 8'(1 + i % 16),
                   8'(30 + i), 0, 0);
      read_used(31);
      send_item(ntpt_pkg::KIND_CLEAR_IN, 0, 0, 0, 0);
   endtask

   task automatic test_random(input int count, input int tx, input int rx);
      int pick, s;
      logic [7:0] ch, nt;
      tx_idle = tx;
      rx_idle = rx;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         ch = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
         nt = ($urandom_range(9) == 0) ? 8'($urandom) :
              8'($urandom_range(vis_low, (vis_high > vis_low) ? vis_high : vis_low));
         if (pick < 22)
            send_item($urandom_range(1) ? ntpt_pkg::KIND_IN_ON : ntpt_pkg::KIND_OUT_ON,
                      ch, nt, 0, 0);
         else if (pick < 38)
            send_item($urandom_range(1) ? ntpt_pkg::KIND_IN_OFF : ntpt_pkg::KIND_OUT_OFF,
                      ch, nt, 0, 0);
         else if (pick < 41)
            send_item(ntpt_pkg::KIND_RELEASE, ch, 8'($urandom), $urandom, 5'($urandom));
         else if (pick < 43)
            send_item(ntpt_pkg::KIND_CLEAR_IN, 8'($urandom), 8'($urandom), $urandom,
                      5'($urandom));
         else if (pick < 60)
            tick_by(($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 400));
         else if (pick < 70)
            send_item($urandom_range(1) ? ntpt_pkg::KIND_QUERY_IN : ntpt_pkg::KIND_QUERY_OUT,
                      ch, nt, 0, 0);
         else if (pick < 97) begin
            s = $urandom_range(ntpt_pkg::MAX_TRAILS - 1);
            if (tr_used[s]) send_item(ntpt_pkg::KIND_READ, ch, nt, $urandom, 5'(s));
            else send_item(ntpt_pkg::KIND_QUERY_IN, ch, nt, 0, 0);
         end else
            send_item(4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), ch, nt, $urandom,
                      5'($urandom));
      end
   endtask

   initial begin
      for (int n = 0; n < ntpt_pkg::NOTES; n++) begin
         in_map[n] = '0;
         out_map[n] = '0;
      end
      for (int i = 0; i < ntpt_pkg::MAX_TRAILS; i++) begin
         tr_live[i] = 0; tr_grow[i] = 0; tr_out[i] = 0; tr_used[i] = 0;
         tr_note[i] = 0; tr_chan[i] = 0; tr_top[i] = 0; tr_bot[i] = 0;
         tr_start[i] = 0; tr_end[i] = 0;
      end
      last_tick = 0; ticked = 0; accum = 0;
      vis_low = 21; vis_high = 108; roll_top = 0; roll_bot = 240; margin = 8; ms_px = 20;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_pool_full();
      drain();
      set_regs(0, 127, 1000, 1023, 255, 1);
      test_random(220, 11, 68);
      drain();
      set_regs(60, 40, 0, 1023, 0, 1000);
      test_random(30, 11, 68);
      drain();
      set_regs(0, 127, 0, 1023, 0, 1000);
      test_random(200, 68, 11);
      drain();
      set_regs(10, 120, 700, 100, 0, 0);
      test_random(60, 0, 0);
      drain();
      set_regs(21, 108, 16, 200, 40, 3);
      test_random(180, 0, 0);
      drain();
      if (fails == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ntpt_pkg.sv
hw/rtl/ntpt_div.sv
hw/rtl/note_trail_pool_tracker_core.sv
hw/rtl/ntpt_checker.sv
sim/note_trail_pool_tracker_core_tb.sv
